[design/lqm_pkg.sv]
package lqm_pkg;

	localparam int unsigned SeqW      = 16;
	localparam int unsigned RawW      = 16;
	localparam int unsigned TimeW     = 32;
	localparam int unsigned RssiW     = 8;
	localparam int unsigned SumW      = 40;
	localparam int unsigned CountW    = 32;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 32;
	localparam int unsigned InDataW   = 64;
	localparam int unsigned OutDataW  = 112;
	localparam int unsigned DivSteps  = SumW;
	localparam int unsigned DivCntW   = $clog2(DivSteps + 1);

	localparam logic signed [RssiW-1:0] RssiMin = -8'sd128;
	localparam logic signed [RssiW-1:0] RssiMax = 8'sd127;

	localparam logic [SeqW-1:0]  FwdLimitRst  = 16'd1000;
	localparam logic [SeqW-1:0]  BwdFloorRst  = 16'd60000;
	localparam logic [TimeW-1:0] BwdWindowRst = 32'd10000;
	localparam logic [SeqW-1:0]  DupThreshRst = 16'd3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RX_ENABLE  = 3'd0,
		REG_FWD_LIMIT  = 3'd1,
		REG_BWD_FLOOR  = 3'd2,
		REG_BWD_WINDOW = 3'd3,
		REG_DUP_THRESH = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT
	} state_t;

	typedef enum logic {
		OP_PACKET = 1'b0,
		OP_REPORT = 1'b1
	} opcode_t;

	typedef struct packed {
		logic              receive_enabled;
		logic [SeqW-1:0]   forward_gap_limit;
		logic [SeqW-1:0]   backward_floor;
		logic [TimeW-1:0]  backward_window_ms;
		logic [SeqW-1:0]   duplicate_threshold;
	} cfg_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic [SeqW-1:0]         sequence_number;
		logic signed [RawW-1:0]  signal_strength;
		logic [TimeW-1:0]        time_ms;
	} item_t;

	typedef struct packed {
		logic [CountW-1:0]        received_total;
		logic [SeqW-1:0]          missed_total;
		logic [SeqW-1:0]          window_gaps;
		logic signed [RssiW-1:0]  strength_min;
		logic signed [RssiW-1:0]  strength_max;
		logic                     window_seen;
		logic [SeqW-1:0]          backward_count;
		logic                     duplicate_sender;
		logic                     duplicate_alert;
	} snap_t;

endpackage

[design/link_quality_monitor.sv]
// Link quality monitor: receive-side statistics for a packet radio.
// Input stream (s_*): one transaction per item. s_tuser is the opcode
// (0 = received packet, 1 = report then clear window); s_tdata carries the
// sequence number, raw RSSI and millisecond timestamp.
// Output stream (m_*): exactly one result transaction per input transaction,
// in order, with the counters, RSSI min/max/average and duplicate-sender
// status.
// Configuration (cfg_*): register index and data, always ready; write only
// while no transaction is in flight.
// Timing: the statistics update on the accepting edge; the RSSI average then
// comes from a 40-step radix-2 divider, one quotient bit a cycle. The result
// is loaded into the output register once the divider is done; a new item
// is taken only after that. s_tready is low while an item is in work.
// Stall: the result waits in the output register while m_tready is low;
// the next item is accepted and worked on meanwhile and holds in the final
// state until the register frees up.
// Reset: all statistics clear, the registers take their defaults (receive
// disabled) and m_tvalid drops.
module link_quality_monitor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [lqm_pkg::InDataW-1:0]          s_tdata,  // sequence_number, signal_strength, time_ms
	input  logic                                 s_tuser,  // opcode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// received_total, missed_total, window_gaps, strength_min, strength_max,
	// strength_avg, window_seen, backward_count, duplicate_sender,
	// duplicate_alert, zero pad
	output logic [lqm_pkg::OutDataW-1:0]         m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lqm_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [lqm_pkg::CfgDataW-1:0]         cfg_data
);
	import lqm_pkg::*;

	localparam int unsigned PayloadW = $bits(snap_t) + RssiW;

	state_t                  state_q;
	state_t                  state_d;
	cfg_t                    cfg_q;
	item_t                   item;
	snap_t                   snap;
	logic signed [SumW-1:0]  sum;
	logic [CountW-1:0]       count;
	logic                    s_accept;
	logic                    div_start;
	logic                    div_done;
	logic signed [RssiW-1:0] avg;
	logic                    load_out;
	logic                    m_valid_q;
	logic [OutDataW-1:0]     m_data_q;
	logic [PayloadW-1:0]     payload;

	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign item = '{
		opcode:          opcode_t'(s_tuser),
		sequence_number: s_tdata[15:0],
		signal_strength: s_tdata[31:16],
		time_ms:         s_tdata[63:32]
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.receive_enabled     <= 1'b0;
			cfg_q.forward_gap_limit   <= FwdLimitRst;
			cfg_q.backward_floor      <= BwdFloorRst;
			cfg_q.backward_window_ms  <= BwdWindowRst;
			cfg_q.duplicate_threshold <= DupThreshRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RX_ENABLE:  cfg_q.receive_enabled     <= cfg_data[0];
				REG_FWD_LIMIT:  cfg_q.forward_gap_limit   <= cfg_data[SeqW-1:0];
				REG_BWD_FLOOR:  cfg_q.backward_floor      <= cfg_data[SeqW-1:0];
				REG_BWD_WINDOW: cfg_q.backward_window_ms  <= cfg_data[TimeW-1:0];
				REG_DUP_THRESH: cfg_q.duplicate_threshold <= cfg_data[SeqW-1:0];
				default: ;
			endcase
		end
	end

	lqm_stats u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.apply          (s_accept),
		.item           (item),
		.cfg            (cfg_q),
		.snap           (snap),
		.strength_sum   (sum),
		.strength_count (count)
	);

	lqm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum),
		.divisor  (count),
		.done     (div_done),
		.quotient (avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_START;
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done && (!m_valid_q || m_tready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign payload = {
		snap.duplicate_alert,
		snap.duplicate_sender,
		snap.backward_count,
		snap.window_seen,
		avg,
		snap.strength_max,
		snap.strength_min,
		snap.window_gaps,
		snap.missed_total,
		snap.received_total
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			m_data_q <= OutDataW'(payload);
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

[design/lqm_divider.sv]
module lqm_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [lqm_pkg::SumW-1:0]   dividend,
	input  logic [lqm_pkg::CountW-1:0]        divisor,
	output logic                              done,
	output logic signed [lqm_pkg::RssiW-1:0]  quotient
);
	import lqm_pkg::*;

	logic [CountW-1:0]   rem_q;
	logic [SumW-1:0]     quo_q;
	logic [CountW-1:0]   div_q;
	logic [DivCntW-1:0]  cnt_q;
	logic                busy_q;
	logic                done_q;
	logic                neg_q;
	logic                zero_q;
	logic [CountW:0]     trial;
	logic [SumW-1:0]     mag;
	logic [RssiW-1:0]    quo_lo;

	assign mag   = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[SumW-1]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			neg_q  <= 1'b0;
			zero_q <= 1'b1;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DivCntW'(DivSteps);
			rem_q  <= '0;
			quo_q  <= mag;
			div_q  <= divisor;
			neg_q  <= dividend[SumW-1];
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			if (!trial[CountW]) begin
				rem_q <= trial[CountW-1:0];
				quo_q <= {quo_q[SumW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CountW-2:0], quo_q[SumW-1]};
				quo_q <= {quo_q[SumW-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DivCntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quo_lo   = quo_q[RssiW-1:0];
	assign done     = done_q;
	assign quotient = zero_q ? '0 : (neg_q ? $signed(~quo_lo + 1'b1) : $signed(quo_lo));

endmodule

[design/lqm_stats.sv]
module lqm_stats (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             apply,
	input  lqm_pkg::item_t                   item,
	input  lqm_pkg::cfg_t                    cfg,
	output lqm_pkg::snap_t                   snap,
	output logic signed [lqm_pkg::SumW-1:0]  strength_sum,
	output logic [lqm_pkg::CountW-1:0]       strength_count
);
	import lqm_pkg::*;

	logic [SeqW-1:0]           last_seq_q;
	logic                      have_last_q;
	logic [SeqW-1:0]           gaps_q;
	logic [SeqW-1:0]           missed_q;
	logic [SeqW-1:0]           bwd_run_q;
	logic [TimeW-1:0]          bwd_time_q;
	logic                      dup_flag_q;
	logic [CountW-1:0]         pkt_cnt_q;
	logic signed [RssiW-1:0]   win_min_q;
	logic signed [RssiW-1:0]   win_max_q;
	logic                      win_valid_q;
	logic signed [SumW-1:0]    sum_q;
	logic [CountW-1:0]         cnt_q;
	snap_t                     snap_q;

	logic signed [RssiW-1:0]   rssi;
	logic [SeqW-1:0]           diff;
	logic                      is_fwd;
	logic                      is_bwd;
	logic [SeqW-1:0]           run_base;
	logic [SeqW-1:0]           gaps_d;
	logic [SeqW-1:0]           missed_d;
	logic [SeqW-1:0]           bwd_run_d;
	logic [TimeW-1:0]          bwd_time_d;
	logic                      dup_flag_d;
	logic                      alert_d;
	logic signed [RssiW-1:0]   win_min_d;
	logic signed [RssiW-1:0]   win_max_d;
	logic signed [SumW-1:0]    sum_d;
	logic [CountW-1:0]         cnt_d;
	logic                      is_packet;
	snap_t                     snap_d;

	always_comb begin
		if (item.signal_strength < RawW'(signed'(RssiMin)))
			rssi = RssiMin;
		else if (item.signal_strength > RawW'(signed'(RssiMax)))
			rssi = RssiMax;
		else
			rssi = item.signal_strength[RssiW-1:0];

		is_packet = cfg.receive_enabled && (item.opcode == OP_PACKET);

		diff   = item.sequence_number - last_seq_q;
		is_fwd = have_last_q && (diff > SeqW'(1)) && (diff < cfg.forward_gap_limit);
		is_bwd = have_last_q && !is_fwd && ((diff == '0) || (diff > cfg.backward_floor));

		gaps_d   = is_fwd ? (gaps_q + diff - 1'b1) : gaps_q;
		missed_d = is_fwd ? (missed_q + diff - 1'b1) : missed_q;

		run_base = ((bwd_run_q != '0) && ((item.time_ms - bwd_time_q) > cfg.backward_window_ms))
			? '0 : bwd_run_q;
		bwd_run_d  = bwd_run_q;
		bwd_time_d = bwd_time_q;
		if (is_bwd) begin
			bwd_time_d = item.time_ms;
			bwd_run_d  = (run_base != '1) ? (run_base + 1'b1) : run_base;
		end

		alert_d    = !dup_flag_q && (bwd_run_d >= cfg.duplicate_threshold);
		dup_flag_d = dup_flag_q || alert_d;

		if (!win_valid_q) begin
			win_min_d = rssi;
			win_max_d = rssi;
		end else begin
			win_min_d = (rssi < win_min_q) ? rssi : win_min_q;
			win_max_d = (rssi > win_max_q) ? rssi : win_max_q;
		end

		if (cnt_q != '1) begin
			sum_d = sum_q + SumW'(rssi);
			cnt_d = cnt_q + 1'b1;
		end else begin
			sum_d = sum_q;
			cnt_d = cnt_q;
		end

		if (is_packet) begin
			snap_d.received_total   = pkt_cnt_q + 1'b1;
			snap_d.missed_total     = missed_d;
			snap_d.window_gaps      = gaps_d;
			snap_d.strength_min     = win_min_d;
			snap_d.strength_max     = win_max_d;
			snap_d.window_seen      = 1'b1;
			snap_d.backward_count   = bwd_run_d;
			snap_d.duplicate_sender = dup_flag_d;
			snap_d.duplicate_alert  = alert_d;
		end else begin
			snap_d.received_total   = pkt_cnt_q;
			snap_d.missed_total     = missed_q;
			snap_d.window_gaps      = gaps_q;
			snap_d.strength_min     = win_valid_q ? win_min_q : '0;
			snap_d.strength_max     = win_valid_q ? win_max_q : '0;
			snap_d.window_seen      = win_valid_q;
			snap_d.backward_count   = bwd_run_q;
			snap_d.duplicate_sender = dup_flag_q;
			snap_d.duplicate_alert  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q  <= '0;
			have_last_q <= 1'b0;
			gaps_q      <= '0;
			missed_q    <= '0;
			bwd_run_q   <= '0;
			bwd_time_q  <= '0;
			dup_flag_q  <= 1'b0;
			pkt_cnt_q   <= '0;
			win_min_q   <= '0;
			win_max_q   <= '0;
			win_valid_q <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			snap_q      <= '0;
		end else if (apply) begin
			snap_q <= snap_d;
			if (is_packet) begin
				last_seq_q  <= item.sequence_number;
				have_last_q <= 1'b1;
				gaps_q      <= gaps_d;
				missed_q    <= missed_d;
				bwd_run_q   <= bwd_run_d;
				bwd_time_q  <= bwd_time_d;
				dup_flag_q  <= dup_flag_d;
				pkt_cnt_q   <= pkt_cnt_q + 1'b1;
				win_min_q   <= win_min_d;
				win_max_q   <= win_max_d;
				win_valid_q <= 1'b1;
				sum_q       <= sum_d;
				cnt_q       <= cnt_d;
			end else if (cfg.receive_enabled) begin
				// report: window extremes and gap count restart
				win_valid_q <= 1'b0;
				gaps_q      <= '0;
			end
		end
	end

	assign snap           = snap_q;
	assign strength_sum   = sum_q;
	assign strength_count = cnt_q;

endmodule

[design/lqm_checker.sv]
module lqm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lqm_pkg::OutDataW-1:0]  m_tdata
);
	import lqm_pkg::*;

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted twice in a row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// alert only with the sticky flag set
	a_alert_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[106]) |-> m_tdata[105])
		else $error("alert without duplicate flag");

	// empty window reports zero extremes
	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[88]) |-> (m_tdata[79:64] == '0))
		else $error("extremes set on empty window");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OutDataW-1:107] == '0))
		else $error("pad bits not zero");

endmodule

bind link_quality_monitor lqm_checker u_lqm_checker (.*);
